### rtl/kvt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kvt_pkg;

  // Widest position used anywhere (CAPACITY is at most 256)
  localparam int POS_W = 8;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_READ   = 2'd3
  } kvt_cmd_t;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_MISS  = 2'd1,
    STS_FULL  = 2'd2,
    STS_RANGE = 2'd3
  } kvt_status_t;

  // Store update broadcast from the controller to every cell
  typedef struct packed {
    logic             wr_val;   // write value at pos
    logic             wr_key;   // write key at pos too (new entry)
    logic             shift;    // cells at pos and above take their upper neighbor
    logic [POS_W-1:0] pos;
  } kvt_ctl_t;

endpackage

`default_nettype wire

### rtl/kvt_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface kvt_in_if #(
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
);
  logic                       valid;
  logic                       ready;
  logic [1:0]                 command;
  logic signed [KEY_BITS-1:0] key;
  logic [VALUE_BITS-1:0]      value_in;
  logic [3:0]                 index;

  modport source (output valid, command, key, value_in, index, input ready);
  modport sink   (input valid, command, key, value_in, index, output ready);
endinterface

interface kvt_out_if #(
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32,
  parameter int CNT_W      = 5
);
  logic                       valid;
  logic                       ready;
  logic [1:0]                 status;
  logic signed [KEY_BITS-1:0] key_out;
  logic [VALUE_BITS-1:0]      value_out;
  logic [CNT_W-1:0]           entry_count;
  logic signed [KEY_BITS:0]   next_key;

  modport source (output valid, status, key_out, value_out, entry_count, next_key,
                  input ready);
  modport sink   (input valid, status, key_out, value_out, entry_count, next_key,
                  output ready);
endinterface

`default_nettype wire

### rtl/kvt_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module kvt_cell
  import kvt_pkg::*;
#(
  parameter int INDEX      = 0,
  parameter int CAPACITY   = 16,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32,
  parameter int CNT_W      = 5
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // broadcast request
  input  wire kvt_cmd_t              cmd_i,
  input  wire logic [KEY_BITS-1:0]   key_i,
  input  wire logic [VALUE_BITS-1:0] value_i,
  input  wire logic [3:0]            idx_i,
  input  wire logic [CNT_W-1:0]      count_i,
  input  wire kvt_ctl_t              ctl_i,
  // search token from the lower neighbor
  input  wire logic                  tok_valid_i,
  input  wire logic                  tok_found_i,
  input  wire logic [POS_W-1:0]      tok_pos_i,
  input  wire logic [KEY_BITS-1:0]   tok_key_i,
  input  wire logic [VALUE_BITS-1:0] tok_value_i,
  // search token to the upper neighbor
  output logic                       tok_valid_o,
  output logic                       tok_found_o,
  output logic [POS_W-1:0]           tok_pos_o,
  output logic [KEY_BITS-1:0]        tok_key_o,
  output logic [VALUE_BITS-1:0]      tok_value_o,
  // upper neighbor's entry, for the shift-down on remove
  input  wire logic [KEY_BITS-1:0]   nb_key_i,
  input  wire logic [VALUE_BITS-1:0] nb_value_i,
  output logic [KEY_BITS-1:0]        key_o,
  output logic [VALUE_BITS-1:0]      value_o
);

  localparam logic [POS_W-1:0] MY_POS = POS_W'(INDEX);

  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] value_r;
  logic                  in_use;
  logic                  hit;
  logic                  at_pos;
  logic                  shift_here;

  assign in_use = 32'(INDEX) < 32'(count_i);
  assign hit    = tok_valid_i && !tok_found_i && in_use &&
                  ((cmd_i == CMD_READ) ? (32'(idx_i) == 32'(INDEX)) : (key_r == key_i));

  assign at_pos     = ctl_i.pos == MY_POS;
  assign shift_here = ctl_i.shift && (ctl_i.pos <= MY_POS) && (INDEX < CAPACITY - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_valid_o <= 1'b0;
    end else begin
      tok_valid_o <= tok_valid_i;
    end
    tok_found_o <= tok_found_i || hit;
    tok_pos_o   <= hit ? MY_POS  : tok_pos_i;
    tok_key_o   <= hit ? key_r   : tok_key_i;
    tok_value_o <= hit ? value_r : tok_value_i;

    if (shift_here) begin
      key_r   <= nb_key_i;
      value_r <= nb_value_i;
    end else if (ctl_i.wr_val && at_pos) begin
      value_r <= value_i;
      if (ctl_i.wr_key) begin
        key_r <= key_i;
      end
    end
  end

  assign key_o   = key_r;
  assign value_o = value_r;

endmodule

`default_nettype wire

### rtl/key_value_table_top.sv
// Channel  Dir  Fields                                            Transfer
// in_ch    in   command, key, value_in, index                     valid & ready
// out_ch   out  status, key_out, value_out, entry_count, next_key valid & ready
//
// One command at a time; the search token walks the cell row one cell per cycle.
// Stores need no reset; count and next-key register reset to 0 and 1.
// A result held on out_ch stalls the final update; in_ch reopens once it is loaded.
`timescale 1ns / 1ps
`default_nettype none

module key_value_table_top
  import kvt_pkg::*;
#(
  parameter int CAPACITY   = 16,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  kvt_in_if.sink    in_ch,
  kvt_out_if.source out_ch
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [KEY_BITS-1:0] KEY_TOP = {1'b0, {(KEY_BITS-1){1'b1}}};

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FIN
  } state_t;

  state_t                     state_r, state_nxt;
  logic                       start_r, start_nxt;
  kvt_cmd_t                   cmd_r, cmd_nxt;
  logic [KEY_BITS-1:0]        key_r, key_nxt;
  logic [VALUE_BITS-1:0]      val_r, val_nxt;
  logic [3:0]                 idx_r, idx_nxt;
  logic [CNT_W-1:0]           count_r, count_nxt;
  logic signed [KEY_BITS:0]   next_r, next_nxt;
  logic                       found_r, found_nxt;
  logic [POS_W-1:0]           fpos_r, fpos_nxt;
  logic [KEY_BITS-1:0]        fkey_r, fkey_nxt;
  logic [VALUE_BITS-1:0]      fval_r, fval_nxt;
  logic                       ovalid_r, ovalid_nxt;
  kvt_status_t                osts_r, osts_nxt;
  logic [KEY_BITS-1:0]        okey_r, okey_nxt;
  logic [VALUE_BITS-1:0]      oval_r, oval_nxt;
  logic signed [KEY_BITS:0]   onext_r, onext_nxt;
  kvt_ctl_t                   ctl;
  logic                       in_fire;
  logic                       fin_go;
  logic signed [KEY_BITS:0]   key_ext;

  logic                  tok_valid [CAPACITY+1];
  logic                  tok_found [CAPACITY+1];
  logic [POS_W-1:0]      tok_pos   [CAPACITY+1];
  logic [KEY_BITS-1:0]   tok_key   [CAPACITY+1];
  logic [VALUE_BITS-1:0] tok_value [CAPACITY+1];
  logic [KEY_BITS-1:0]   st_key    [CAPACITY];
  logic [VALUE_BITS-1:0] st_value  [CAPACITY];
  logic [KEY_BITS-1:0]   nb_key    [CAPACITY];
  logic [VALUE_BITS-1:0] nb_value  [CAPACITY];
  logic [CAPACITY:0]     tok_vec;

  assign tok_valid[0] = start_r;
  assign tok_found[0] = 1'b0;
  assign tok_pos[0]   = '0;
  assign tok_key[0]   = '0;
  assign tok_value[0] = '0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g < CAPACITY - 1) begin : g_nb
      assign nb_key[g]   = st_key[g+1];
      assign nb_value[g] = st_value[g+1];
    end else begin : g_end
      assign nb_key[g]   = st_key[g];
      assign nb_value[g] = st_value[g];
    end

    kvt_cell #(
      .INDEX      (g),
      .CAPACITY   (CAPACITY),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS),
      .CNT_W      (CNT_W)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd_i       (cmd_r),
      .key_i       (key_r),
      .value_i     (val_r),
      .idx_i       (idx_r),
      .count_i     (count_r),
      .ctl_i       (ctl),
      .tok_valid_i (tok_valid[g]),
      .tok_found_i (tok_found[g]),
      .tok_pos_i   (tok_pos[g]),
      .tok_key_i   (tok_key[g]),
      .tok_value_i (tok_value[g]),
      .tok_valid_o (tok_valid[g+1]),
      .tok_found_o (tok_found[g+1]),
      .tok_pos_o   (tok_pos[g+1]),
      .tok_key_o   (tok_key[g+1]),
      .tok_value_o (tok_value[g+1]),
      .nb_key_i    (nb_key[g]),
      .nb_value_i  (nb_value[g]),
      .key_o       (st_key[g]),
      .value_o     (st_value[g])
    );
  end

  for (genvar g = 0; g <= CAPACITY; g++) begin : g_vec
    assign tok_vec[g] = tok_valid[g];
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign fin_go      = (state_r == S_FIN) && (!ovalid_r || out_ch.ready);
  assign key_ext     = {in_ch.key[KEY_BITS-1], in_ch.key};

  always_comb begin
    state_nxt  = state_r;
    start_nxt  = 1'b0;
    cmd_nxt    = cmd_r;
    key_nxt    = key_r;
    val_nxt    = val_r;
    idx_nxt    = idx_r;
    count_nxt  = count_r;
    next_nxt   = next_r;
    found_nxt  = found_r;
    fpos_nxt   = fpos_r;
    fkey_nxt   = fkey_r;
    fval_nxt   = fval_r;
    ovalid_nxt = ovalid_r;
    osts_nxt   = osts_r;
    okey_nxt   = okey_r;
    oval_nxt   = oval_r;
    onext_nxt  = onext_r;
    ctl        = '0;

    if (ovalid_r && out_ch.ready) begin
      ovalid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd_nxt   = kvt_cmd_t'(in_ch.command);
          key_nxt   = in_ch.key;
          val_nxt   = in_ch.value_in;
          idx_nxt   = in_ch.index;
          start_nxt = 1'b1;
          state_nxt = S_WALK;
          // next-key is raised before the search, even if the table is full
          if ((kvt_cmd_t'(in_ch.command) == CMD_INSERT) && (key_ext >= next_r) &&
              !((KEY_BITS >= 64) && (in_ch.key == KEY_TOP))) begin
            next_nxt = key_ext + (KEY_BITS+1)'(1);
          end
        end
      end
      S_WALK: begin
        if (tok_valid[CAPACITY]) begin
          found_nxt = tok_found[CAPACITY];
          fpos_nxt  = tok_pos[CAPACITY];
          fkey_nxt  = tok_key[CAPACITY];
          fval_nxt  = tok_value[CAPACITY];
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (fin_go) begin
          ovalid_nxt = 1'b1;
          osts_nxt   = STS_OK;
          okey_nxt   = fkey_r;
          oval_nxt   = fval_r;
          // next-key is latched with the result; the next accept may raise next_r
          onext_nxt  = next_r;
          state_nxt  = S_IDLE;
          case (cmd_r)
            CMD_LOOKUP: begin
              if (!found_r) osts_nxt = STS_MISS;
            end
            CMD_INSERT: begin
              okey_nxt = key_r;
              oval_nxt = val_r;
              if (found_r) begin
                ctl.wr_val = 1'b1;
                ctl.pos    = fpos_r;
              end else if (32'(count_r) < CAPACITY) begin
                ctl.wr_val = 1'b1;
                ctl.wr_key = 1'b1;
                ctl.pos    = POS_W'(count_r);
                count_nxt  = count_r + CNT_W'(1);
              end else begin
                osts_nxt = STS_FULL;
              end
            end
            CMD_REMOVE: begin
              if (found_r) begin
                ctl.shift = 1'b1;
                ctl.pos   = fpos_r;
                count_nxt = count_r - CNT_W'(1);
              end else begin
                osts_nxt = STS_MISS;
              end
            end
            default: begin
              if (!found_r) osts_nxt = STS_RANGE;
            end
          endcase
          if (osts_nxt != STS_OK) begin
            okey_nxt = '0;
            oval_nxt = '0;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      start_r  <= 1'b0;
      count_r  <= '0;
      next_r   <= (KEY_BITS+1)'(1);
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      start_r  <= start_nxt;
      count_r  <= count_nxt;
      next_r   <= next_nxt;
      ovalid_r <= ovalid_nxt;
    end
    cmd_r   <= cmd_nxt;
    key_r   <= key_nxt;
    val_r   <= val_nxt;
    idx_r   <= idx_nxt;
    found_r <= found_nxt;
    fpos_r  <= fpos_nxt;
    fkey_r  <= fkey_nxt;
    fval_r  <= fval_nxt;
    osts_r  <= osts_nxt;
    okey_r  <= okey_nxt;
    oval_r  <= oval_nxt;
    onext_r <= onext_nxt;
  end

  assign out_ch.valid       = ovalid_r;
  assign out_ch.status      = osts_r;
  assign out_ch.key_out     = okey_r;
  assign out_ch.value_out   = oval_r;
  assign out_ch.entry_count = count_r;
  assign out_ch.next_key    = onext_r;

  // only one search token in the row at a time
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_vec))
    else $error("more than one search token in the cell row");

  a_token_walk: assert property (@(posedge clk) disable iff (!rst_n)
    tok_valid[CAPACITY] |-> state_r == S_WALK)
    else $error("token left the row outside of a walk");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= CAPACITY)
    else $error("entry count above capacity");

  a_full_sts: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && osts_r == STS_FULL) |-> 32'(count_r) == CAPACITY)
    else $error("full status with room left");

  a_remove_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_go && cmd_r == CMD_REMOVE && found_r) |=> count_r == $past(count_r) - CNT_W'(1))
    else $error("remove hit did not lower the count");

endmodule

`default_nettype wire
